// File: rtl/bbct_pkg.sv
// Package for the block buffer cache tag manager: request and status codes,
// sequencer states and default sizes. No dependencies.
package bbct_pkg;

    localparam int NUM_ENTRIES_DEF = 32;
    localparam int NUM_BUCKETS_DEF = 13;
    localparam int COUNT_BITS_DEF  = 8;

    // Key is {device, block}; the remainder unit folds in one key byte a cycle.
    localparam int KEY_W        = 64;
    localparam int MOD_BITS_CYC = 8;
    localparam int MOD_CYCLES   = KEY_W / MOD_BITS_CYC;
    localparam int MOD_CNT_W    = $clog2(MOD_CYCLES);

    typedef enum logic [1:0] {
        REQ_GET     = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_PIN     = 2'd2,
        REQ_UNPIN   = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_MISS     = 3'd1,
        ST_NO_FREE  = 3'd2,
        ST_NOT_USED = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_FETCH,
        S_WAIT,
        S_FINISH
    } state_t;

endpackage

// File: rtl/bbct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/block_buffer_cache_tags.sv
// Tag manager for a disk block buffer cache: hit/allocate lookup, reference
// counts, bucket index. Depends on bbct_pkg and bbct_ram.
//
// Usage
//   Input channel (s_*): one request per handshake. A get names a block by
//   s_device / s_block_number; release, pin and unpin name an entry by
//   s_target_buffer. Result channel (m_*): exactly one result per request,
//   carrying the entry index, the bucket index, the disk-read flag and status.
//   One request at a time. A get walks every entry through the tag RAM read
//   port (then a tail state for the last read, a settle state and a finish
//   state) while the shared remainder unit folds the 64-bit key in one byte a
//   cycle; at the default 32 entries the walk is the longer of the two.
//   Release, pin and unpin fetch the entry, run the remainder unit on the
//   stored tag, settle and finish. A request that names an entry not in use
//   goes from idle straight to the finish state. s_ready is high only in idle.
//   The result sits in an output register; the next request is accepted while
//   it waits. If the receiver stalls and a second result is ready, the
//   sequencer holds in its final state, state unchanged, until the slot frees.
//   Reset clears all in-use flags, the sequencer and the output valid; the tag
//   RAM keeps whatever it held, every read being gated by the in-use flags.
module block_buffer_cache_tags #(
    parameter int NUM_ENTRIES = bbct_pkg::NUM_ENTRIES_DEF,
    parameter int NUM_BUCKETS = bbct_pkg::NUM_BUCKETS_DEF,
    parameter int COUNT_BITS  = bbct_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_device,
    input  logic [31:0] s_block_number,
    input  logic [4:0]  s_target_buffer,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_buffer_index,
    output logic [3:0]  m_bucket_index,
    output logic        m_needs_read,
    output logic [2:0]  m_status
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int REM_W = $clog2(NUM_BUCKETS + 1);
    localparam int ENT_W = bbct_pkg::KEY_W + COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
    localparam logic [bbct_pkg::MOD_CNT_W-1:0] MOD_LAST =
        bbct_pkg::MOD_CNT_W'(bbct_pkg::MOD_CYCLES - 1);

    // Remainder step operand {remainder, key byte} and its reciprocal constant.
    // The shift covers the operand width plus the modulus width, so the
    // quotient from the multiply is exact over the whole operand range.
    localparam int X_W      = REM_W + bbct_pkg::MOD_BITS_CYC;
    localparam int RECIP_SH = X_W + REM_W;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << RECIP_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));
    localparam logic [X_W-1:0] BUCKETS_X = X_W'(NUM_BUCKETS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    bbct_pkg::state_t    state_reg, state_next;
    bbct_pkg::req_type_t op_reg, op_next;

    logic [bbct_pkg::KEY_W-1:0] key_reg, key_next;
    logic [4:0]                 tgt_raw_reg, tgt_raw_next;
    logic                       bad_reg, bad_next;
    logic [IDX_W-1:0]           scan_reg, scan_next;
    logic                       cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]           cmp_idx_reg, cmp_idx_next;
    logic                       hit_found_reg, hit_found_next;
    logic                       free_found_reg, free_found_next;
    logic [IDX_W-1:0]           free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]           ent_idx_reg, ent_idx_next;
    logic [COUNT_BITS-1:0]      ent_cnt_reg, ent_cnt_next;
    logic                       ent_valid_reg, ent_valid_next;
    logic [NUM_ENTRIES-1:0]     in_use_reg, in_use_next;

    // Shared remainder unit: key mod NUM_BUCKETS, one key byte a cycle.
    logic [bbct_pkg::KEY_W-1:0]     mod_key_reg, mod_key_next;
    logic [bbct_pkg::MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic                           mod_busy_reg, mod_busy_next;
    logic [REM_W-1:0]               rem_reg, rem_next;

    logic             m_valid_reg, m_valid_next;
    logic [4:0]       m_index_reg, m_index_next;
    logic [3:0]       m_bucket_reg, m_bucket_next;
    logic             m_read_reg, m_read_next;
    bbct_pkg::status_t m_status_reg, m_status_next;

    // RAM port signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    // Helpers
    logic                       accept;
    logic                       out_free;
    logic [IDX_W-1:0]           tgt_idx;
    logic                       tgt_ok;
    logic [bbct_pkg::KEY_W-1:0] rd_key;
    logic [COUNT_BITS-1:0]      rd_cnt;
    logic                       rd_valid;
    logic                       cmp_hit;
    logic                       cmp_free;
    logic                       mod_start;
    logic [bbct_pkg::KEY_W-1:0] mod_start_key;
    logic [X_W-1:0]             mod_x;
    logic [PROD_W-1:0]          mod_prod;
    logic [X_W-1:0]             mod_q;
    logic [X_W-1:0]             mod_qn;
    logic [REM_W-1:0]           mod_r;
    logic [COUNT_BITS-1:0]      dec_cnt;

    bbct_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_ENTRIES)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == bbct_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign tgt_idx = IDX_W'(s_target_buffer);
    assign tgt_ok  = (32'(s_target_buffer) < 32'(NUM_ENTRIES)) && in_use_reg[tgt_idx];

    // RAM entry layout: {tag key, count, data valid}
    assign rd_key   = ram_rdata[ENT_W-1 -: bbct_pkg::KEY_W];
    assign rd_cnt   = ram_rdata[COUNT_BITS:1];
    assign rd_valid = ram_rdata[0];

    assign cmp_hit  = cmp_valid_reg && in_use_reg[cmp_idx_reg] && (rd_cnt != '0)
                      && (rd_key == key_reg);
    assign cmp_free = cmp_valid_reg && !in_use_reg[cmp_idx_reg];

    assign dec_cnt = (ent_cnt_reg != '0) ? (ent_cnt_reg - 1'b1) : ent_cnt_reg;

    // Remainder step: append the next key byte to the running remainder and
    // reduce it with a reciprocal multiply, then take back quotient * modulus.
    assign mod_x    = {rem_reg, mod_key_reg[bbct_pkg::KEY_W-1 -: bbct_pkg::MOD_BITS_CYC]};
    assign mod_prod = PROD_W'(mod_x) * PROD_W'(RECIP);
    assign mod_q    = mod_prod[RECIP_SH +: X_W];
    assign mod_qn   = mod_q * BUCKETS_X;
    assign mod_r    = REM_W'(mod_x - mod_qn);

    // ------------------------------------------------------------------
    // Sequencer: next state, scan bookkeeping, RAM write, result load
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        tgt_raw_next    = tgt_raw_reg;
        bad_next        = bad_reg;
        scan_next       = scan_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ent_idx_next    = ent_idx_reg;
        ent_cnt_next    = ent_cnt_reg;
        ent_valid_next  = ent_valid_reg;
        in_use_next     = in_use_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_index_next  = m_index_reg;
        m_bucket_next = m_bucket_reg;
        m_read_next   = m_read_reg;
        m_status_next = m_status_reg;

        ram_we    = 1'b0;
        ram_waddr = ent_idx_reg;
        ram_wdata = {key_reg, ent_cnt_reg, 1'b1};
        ram_raddr = scan_reg;

        mod_start     = 1'b0;
        mod_start_key = {s_device, s_block_number};

        // Record the first hit and the lowest free entry as read data returns.
        if (cmp_hit && !hit_found_reg) begin
            hit_found_next = 1'b1;
            ent_idx_next   = cmp_idx_reg;
            ent_cnt_next   = rd_cnt;
            ent_valid_next = rd_valid;
        end
        if (cmp_free && !free_found_reg) begin
            free_found_next = 1'b1;
            free_idx_next   = cmp_idx_reg;
        end

        unique case (state_reg)
            bbct_pkg::S_IDLE: begin
                ram_raddr = tgt_idx;
                if (accept) begin
                    op_next         = bbct_pkg::req_type_t'(s_req_type);
                    tgt_raw_next    = s_target_buffer;
                    bad_next        = 1'b0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    scan_next       = '0;
                    ent_idx_next    = tgt_idx;
                    if (bbct_pkg::req_type_t'(s_req_type) == bbct_pkg::REQ_GET) begin
                        key_next   = {s_device, s_block_number};
                        mod_start  = 1'b1;
                        state_next = bbct_pkg::S_SCAN;
                    end else if (tgt_ok) begin
                        state_next = bbct_pkg::S_FETCH;
                    end else begin
                        bad_next   = 1'b1;
                        state_next = bbct_pkg::S_FINISH;
                    end
                end
            end
            bbct_pkg::S_SCAN: begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_reg;
                if (scan_reg == LAST_IDX) begin
                    state_next = bbct_pkg::S_TAIL;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            bbct_pkg::S_TAIL: begin
                state_next = bbct_pkg::S_WAIT;
            end
            bbct_pkg::S_FETCH: begin
                key_next       = rd_key;
                ent_cnt_next   = rd_cnt;
                ent_valid_next = rd_valid;
                mod_start      = 1'b1;
                mod_start_key  = rd_key;
                state_next     = bbct_pkg::S_WAIT;
            end
            bbct_pkg::S_WAIT: begin
                if (!mod_busy_reg) begin
                    state_next = bbct_pkg::S_FINISH;
                end
            end
            bbct_pkg::S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_read_next   = 1'b0;
                    m_status_next = bbct_pkg::ST_DONE;
                    m_bucket_next = 4'(rem_reg);
                    m_index_next  = tgt_raw_reg;
                    state_next    = bbct_pkg::S_IDLE;
                    if (op_reg == bbct_pkg::REQ_GET) begin
                        priority if (hit_found_reg) begin
                            m_index_next = 5'(ent_idx_reg);
                            if (ent_cnt_reg == COUNT_MAX) begin
                                m_status_next = bbct_pkg::ST_OVERFLOW;
                            end else begin
                                ram_we      = 1'b1;
                                ram_wdata   = {key_reg, ent_cnt_reg + 1'b1, 1'b1};
                                m_read_next = !ent_valid_reg;
                            end
                        end else if (free_found_reg) begin
                            m_index_next  = 5'(free_idx_reg);
                            m_status_next = bbct_pkg::ST_MISS;
                            m_read_next   = 1'b1;
                            ram_we        = 1'b1;
                            ram_waddr     = free_idx_reg;
                            ram_wdata     = {key_reg, COUNT_BITS'(1), 1'b1};
                            in_use_next[free_idx_reg] = 1'b1;
                        end else begin
                            m_index_next  = '0;
                            m_status_next = bbct_pkg::ST_NO_FREE;
                        end
                    end else if (bad_reg) begin
                        m_bucket_next = '0;
                        m_status_next = bbct_pkg::ST_NOT_USED;
                    end else if (op_reg == bbct_pkg::REQ_PIN) begin
                        if (ent_cnt_reg == COUNT_MAX) begin
                            m_status_next = bbct_pkg::ST_OVERFLOW;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {key_reg, ent_cnt_reg + 1'b1, ent_valid_reg};
                        end
                    end else begin
                        // Release and unpin: drop one count, free at zero.
                        ram_we    = 1'b1;
                        ram_wdata = {key_reg, dec_cnt, ent_valid_reg};
                        if (dec_cnt == '0) begin
                            in_use_next[ent_idx_reg] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                state_next = bbct_pkg::S_IDLE;
            end
        endcase

        // Remainder unit sequencing
        mod_key_next  = mod_key_reg;
        mod_cnt_next  = mod_cnt_reg;
        mod_busy_next = mod_busy_reg;
        rem_next      = rem_reg;
        if (mod_start) begin
            mod_key_next  = mod_start_key;
            mod_cnt_next  = '0;
            mod_busy_next = 1'b1;
            rem_next      = '0;
        end else if (mod_busy_reg) begin
            mod_key_next = mod_key_reg << bbct_pkg::MOD_BITS_CYC;
            mod_cnt_next = mod_cnt_reg + 1'b1;
            rem_next     = mod_r;
            if (mod_cnt_reg == MOD_LAST) begin
                mod_busy_next = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers (reset)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbct_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            mod_busy_reg  <= 1'b0;
            in_use_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cmp_valid_reg <= cmp_valid_next;
            mod_busy_reg  <= mod_busy_next;
            in_use_reg    <= in_use_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers (no reset)
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        tgt_raw_reg    <= tgt_raw_next;
        bad_reg        <= bad_next;
        scan_reg       <= scan_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_found_reg  <= hit_found_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        ent_idx_reg    <= ent_idx_next;
        ent_cnt_reg    <= ent_cnt_next;
        ent_valid_reg  <= ent_valid_next;
        mod_key_reg    <= mod_key_next;
        mod_cnt_reg    <= mod_cnt_next;
        rem_reg        <= rem_next;
        m_index_reg    <= m_index_next;
        m_bucket_reg   <= m_bucket_next;
        m_read_reg     <= m_read_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_buffer_index = m_index_reg;
    assign m_bucket_index = m_bucket_reg;
    assign m_needs_read   = m_read_reg;
    assign m_status       = m_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_only_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == bbct_pkg::S_FINISH))
        else $error("tag RAM written outside the finish state");

    a_rem_ready_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbct_pkg::S_FINISH) |-> !mod_busy_reg)
        else $error("result loaded while remainder unit still busy");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != bbct_pkg::S_IDLE))
        else $error("accepted request did not start the sequencer");

    a_miss_marks_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbct_pkg::S_FINISH && out_free && op_reg == bbct_pkg::REQ_GET
         && !hit_found_reg && free_found_reg)
        |=> in_use_reg[$past(free_idx_reg)])
        else $error("allocated entry not marked in use");

endmodule

// File: dv/block_buffer_cache_tags_checker.sv
// Scoreboard for the block buffer cache tag manager: mirrors the tag store,
// predicts one result per accepted request and compares it with the m_ side.
// Depends on bbct_pkg for the request and status codes and default sizes.
module block_buffer_cache_tags_checker
    import bbct_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_device,
    input  logic [31:0] s_block_number,
    input  logic [4:0]  s_target_buffer,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [4:0]  m_buffer_index,
    input  logic [3:0]  m_bucket_index,
    input  logic        m_needs_read,
    input  logic [2:0]  m_status,

    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;

    typedef struct packed {
        logic [4:0] buffer_index;
        logic [3:0] bucket_index;
        logic       needs_read;
        status_t    status;
    } cache_result_t;

    // Shadow of the tag store.
    logic [31:0] cached_dev [NUM_ENTRIES];
    logic [31:0] cached_blk [NUM_ENTRIES];
    int unsigned use_count  [NUM_ENTRIES];
    bit          occupied   [NUM_ENTRIES];
    bit          loaded     [NUM_ENTRIES];

    cache_result_t awaited_results [$];
    int            mismatches;

    function automatic logic [3:0] bucket_of(input logic [31:0] dev, input logic [31:0] blk);
        logic [63:0] key;
        key = {dev, blk};
        return 4'(key % 64'(NUM_BUCKETS));
    endfunction

    // Apply one request to the shadow store and return the result it causes.
    function automatic cache_result_t serve_request(input req_type_t op,
                                                    input logic [31:0] dev,
                                                    input logic [31:0] blk,
                                                    input logic [4:0] tgt);
        cache_result_t res;
        int slot;
        int idx;
        res.buffer_index = '0;
        res.bucket_index = '0;
        res.needs_read   = 1'b0;
        res.status       = ST_DONE;
        if (op == REQ_GET) begin
            res.bucket_index = bucket_of(dev, blk);
            slot = -1;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (slot < 0 && occupied[i] && use_count[i] != 0 &&
                    cached_dev[i] == dev && cached_blk[i] == blk)
                    slot = i;
            end
            if (slot >= 0) begin
                res.buffer_index = 5'(slot);
                if (use_count[slot] >= COUNT_MAX) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    use_count[slot]++;
                    res.needs_read = !loaded[slot];
                    loaded[slot]   = 1'b1;
                end
                return res;
            end
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (slot < 0 && !occupied[i])
                    slot = i;
            end
            if (slot < 0) begin
                res.status = ST_NO_FREE;
                return res;
            end
            occupied[slot]   = 1'b1;
            cached_dev[slot] = dev;
            cached_blk[slot] = blk;
            use_count[slot]  = 1;
            loaded[slot]     = 1'b1;
            res.buffer_index = 5'(slot);
            res.needs_read   = 1'b1;
            res.status       = ST_MISS;
            return res;
        end

        res.buffer_index = tgt;
        idx = int'(tgt);
        if (idx >= NUM_ENTRIES || !occupied[idx]) begin
            res.status = ST_NOT_USED;
            return res;
        end
        res.bucket_index = bucket_of(cached_dev[idx], cached_blk[idx]);
        if (op == REQ_PIN) begin
            if (use_count[idx] >= COUNT_MAX)
                res.status = ST_OVERFLOW;
            else
                use_count[idx]++;
        end else begin
            if (use_count[idx] != 0)
                use_count[idx]--;
            if (use_count[idx] == 0)
                occupied[idx] = 1'b0;
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        cache_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_ENTRIES; i++)
                occupied[i] = 1'b0;
            awaited_results.delete();
            mismatches = 0;
        end else begin
            // Retire the oldest result before queuing the new request.
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: index %0d status %0d",
                           m_buffer_index, m_status);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("buffer_index", want.buffer_index, m_buffer_index);
                    check_field("bucket_index", want.bucket_index, m_bucket_index);
                    check_field("needs_read", want.needs_read, m_needs_read);
                    check_field("status", want.status, m_status);
                end
            end
            if (s_valid && s_ready)
                awaited_results.push_back(serve_request(req_type_t'(s_req_type), s_device,
                                                        s_block_number, s_target_buffer));
        end
        fail_count  <= mismatches;
        outstanding <= awaited_results.size();
    end

endmodule

// File: dv/testbench.sv
// Top of the tag manager testbench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Depends on bbct_pkg, the block and
// block_buffer_cache_tags_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bbct_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
    localparam int TAIL_CYCLES    = 60;    // settle time after the last result
    localparam int POOL_SIZE      = 12;    // tags reused by random gets
    localparam int RANDOM_ITEMS   = 560;
    localparam int COUNT_MAX      = (1 << COUNT_BITS_DEF) - 1;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;

    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type      = REQ_GET;
    logic [31:0] s_device        = '0;
    logic [31:0] s_block_number  = '0;
    logic [4:0]  s_target_buffer = '0;

    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [4:0]  m_buffer_index;
    logic [3:0]  m_bucket_index;
    logic        m_needs_read;
    logic [2:0]  m_status;

    int          fail_count;
    int          outstanding;
    int          idle_cycles     = 0;

    // Idling switches, flipped per batch so some stretches run back to back.
    bit          sender_quiet    = 1'b0;
    bit          receiver_quiet  = 1'b0;

    logic [31:0] pool_dev [POOL_SIZE];
    logic [31:0] pool_blk [POOL_SIZE];

    block_buffer_cache_tags dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_device        (s_device),
        .s_block_number  (s_block_number),
        .s_target_buffer (s_target_buffer),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_buffer_index  (m_buffer_index),
        .m_bucket_index  (m_bucket_index),
        .m_needs_read    (m_needs_read),
        .m_status        (m_status)
    );

    block_buffer_cache_tags_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_device        (s_device),
        .s_block_number  (s_block_number),
        .s_target_buffer (s_target_buffer),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_buffer_index  (m_buffer_index),
        .m_bucket_index  (m_bucket_index),
        .m_needs_read    (m_needs_read),
        .m_status        (m_status),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Abort when neither channel has moved anything for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // No gap while the sender is quiet; else mostly none, sometimes a short one, rarely a long pause.
    function automatic int next_gap();
        int r;
        if (sender_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 1;
        if (r < 90)
            return $urandom_range(2, 5);
        return $urandom_range(15, 50);
    endfunction

    // Lean on the all-zero and all-one patterns now and then.
    function automatic logic [31:0] random_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // Result side: hold ready high for a while, then, unless the receiver is quiet, drop it for a stall.
    initial begin
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (!receiver_quiet) begin
                m_ready <= 1'b0;
                repeat (stall_len()) @(posedge aclk);
            end
        end
    end

    // Present one request and hold it until the block takes it. Valid stays
    // high across back-to-back requests; only a gap or a drain drops it.
    task automatic issue_request(input req_type_t op, input logic [31:0] dev,
                                 input logic [31:0] blk, input logic [4:0] tgt);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= op;
        s_device        <= dev;
        s_block_number  <= blk;
        s_target_buffer <= tgt;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Entry-directed request with noise on the unused tag fields.
    task automatic touch_entry(input req_type_t op, input int idx);
        issue_request(op, $urandom, $urandom, 5'(idx));
    endtask

    // Get with noise on the unused target field.
    task automatic get_block(input logic [31:0] dev, input logic [31:0] blk);
        issue_request(REQ_GET, dev, blk, 5'($urandom_range(0, 31)));
    endtask

    // Hold off the sender until every outstanding result has come back. The
    // counter is registered, so the loop always waits on the clock before it looks.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        logic [31:0] sat_dev;
        logic [31:0] sat_blk;
        int          pick;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme tags, hit, count walk down to free, requests on
        // entries not in use, last entry index.
        get_block(32'h0000_0000, 32'h0000_0000);      // miss into entry 0
        get_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);      // miss into entry 1
        get_block(32'h0000_0000, 32'h0000_0000);      // hit, no read
        touch_entry(REQ_PIN, 0);
        touch_entry(REQ_UNPIN, 0);
        touch_entry(REQ_RELEASE, 0);
        touch_entry(REQ_RELEASE, 0);                  // count reaches zero, frees
        touch_entry(REQ_RELEASE, 0);                  // now not in use
        touch_entry(REQ_PIN, 0);
        touch_entry(REQ_UNPIN, 0);
        touch_entry(REQ_UNPIN, 1);                    // unpin frees too
        touch_entry(REQ_RELEASE, 31);
        get_block(32'h8000_0000, 32'h0000_0001);
        get_block(32'h0000_0001, 32'h8000_0000);
        get_block(32'hAAAA_AAAA, 32'h5555_5555);
        get_block(32'h5555_5555, 32'hAAAA_AAAA);
        touch_entry(REQ_PIN, 31);
        touch_entry(REQ_RELEASE, 0);
        touch_entry(REQ_RELEASE, 1);
        touch_entry(REQ_UNPIN, 2);
        touch_entry(REQ_RELEASE, 3);

        // Let the block go fully idle once before the bulk traffic.
        drain_results();

        // Fill every entry, then ask for one more block with no room left.
        for (int i = 0; i < 32; i++)
            get_block(32'h0000_0100 + i, $urandom);
        get_block($urandom, $urandom);                // no free entry
        get_block(32'h0000_0105, 32'h0000_0000);      // same device, other block
        touch_entry(REQ_PIN, 31);
        for (int i = 0; i < 32; i++)
            touch_entry(REQ_RELEASE, i);
        touch_entry(REQ_UNPIN, 31);
        touch_entry(REQ_RELEASE, 31);                 // already free

        // Saturate the count of one entry through a mix of pins and hits,
        // then push past the top from both sides.
        sat_dev = 32'h0000_0ABC;
        sat_blk = $urandom;
        get_block(sat_dev, sat_blk);
        for (int k = 1; k < COUNT_MAX; k++) begin
            if ($urandom_range(0, 1) == 0)
                touch_entry(REQ_PIN, 0);
            else
                get_block(sat_dev, sat_blk);
        end
        touch_entry(REQ_PIN, 0);                      // overflow on pin
        get_block(sat_dev, sat_blk);                  // overflow on hit
        touch_entry(REQ_RELEASE, 0);
        get_block(sat_dev, sat_blk);                  // back to the top, no read
        drain_results();

        // Random traffic over a small tag pool so gets hit as often as they
        // miss; some pool tags share a device or a block to stress the compare.
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_dev[i] = (i % 3 == 0) ? $urandom : pool_dev[i - 1];
            pool_blk[i] = (i % 4 == 1) ? pool_blk[i - 1] : $urandom;
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 80 == 0) begin
                sender_quiet   = ($urandom_range(0, 3) == 0);
                receiver_quiet = ($urandom_range(0, 3) == 0);
            end
            if (n % 150 == 149)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                if ($urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, POOL_SIZE - 1);
                    get_block(pool_dev[pick], pool_blk[pick]);
                end else begin
                    get_block(random_word(), random_word());
                end
            end else if (pick < 68) begin
                touch_entry(REQ_RELEASE, $urandom_range(0, 31));
            end else if (pick < 80) begin
                touch_entry(REQ_PIN, $urandom_range(0, 31));
            end else begin
                touch_entry(REQ_UNPIN, $urandom_range(0, 31));
            end
        end

        // Drop valid, wait for the last result, then let the block settle.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
